// ===== hw/rtl/serial_frame_receiver_assert.svh =====
// ============================================================================
// Assertion macros for the serial frame receiver
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ============================================================================
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("serial frame receiver check failed");
`define SFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial frame receiver check failed");
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial frame receiver check failed");
`else
`define SFR_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial frame receiver package
// Field widths, register indexes, reset values and the command, status and
// result types shared by the receiver modules.
// ============================================================================
package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 5;
    localparam int LEN_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_CODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CODE_C    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE       = 3'd5;

    localparam logic [BYTE_W-1:0] RST_START_BYTE     = 8'h73;
    localparam logic [BYTE_W-1:0] RST_DIRECTION_CODE = 8'h22;
    localparam logic [BYTE_W-1:0] RST_FUNC_CODE_A    = 8'h01;
    localparam logic [BYTE_W-1:0] RST_FUNC_CODE_B    = 8'h02;
    localparam logic [BYTE_W-1:0] RST_FUNC_CODE_C    = 8'hEE;
    localparam logic [BYTE_W-1:0] RST_END_BYTE       = 8'h65;

    typedef struct packed {
        logic sum_load;
        logic sum_add;
        logic func_load;
        logic len_load;
        logic data_write;
        logic out_empty;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_dir;
        logic is_func;
        logic len_ok;
        logic len_zero;
        logic fill_last;
        logic sum_ok;
        logic is_end;
        logic held_zero;
        logic out_free;
        logic emit_last;
    } sts_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] frame_function;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_frame;
        logic              empty_frame;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sfr_rx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Received byte channel
// Valid/ready channel that carries one received serial byte per beat.
// ============================================================================
interface sfr_rx_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sfr_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Frame result channel
// Valid/ready channel that carries one payload result per beat.
// ============================================================================
interface sfr_res_if import sfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] frame_function;
    logic [LEN_W-1:0]  frame_length;
    logic              last_of_frame;
    logic              empty_frame;

    modport source (
        output valid, output payload_byte, output byte_position,
        output frame_function, output frame_length, output last_of_frame,
        output empty_frame, input ready
    );
    modport sink (
        input valid, input payload_byte, input byte_position,
        input frame_function, input frame_length, input last_of_frame,
        input empty_frame, output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/sfr_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Configuration write channel
// Valid/ready channel that carries a register index and write data per beat.
// ============================================================================
interface sfr_cfg_if import sfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial frame receiver controller
// Frame state machine that steers the datapath and paces the result run.
// ============================================================================
`include "serial_frame_receiver_assert.svh"

module sfr_ctrl import sfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rx_valid,
    output logic      rx_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [3:0] ST_HUNT    = 4'd0;
    localparam logic [3:0] ST_DIR     = 4'd1;
    localparam logic [3:0] ST_FUNC    = 4'd2;
    localparam logic [3:0] ST_LEN     = 4'd3;
    localparam logic [3:0] ST_DATA    = 4'd4;
    localparam logic [3:0] ST_SUM     = 4'd5;
    localparam logic [3:0] ST_END     = 4'd6;
    localparam logic [3:0] ST_EMIT_RD = 4'd7;
    localparam logic [3:0] ST_EMIT_LD = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        rx_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_DIR:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    if (sts.is_dir)
                    begin
                        cmd.sum_add = 1'b1;
                        state_next  = ST_FUNC;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_FUNC:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    if (sts.is_func)
                    begin
                        cmd.func_load = 1'b1;
                        cmd.sum_add   = 1'b1;
                        state_next    = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_LEN:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    if (sts.len_ok)
                    begin
                        cmd.len_load = 1'b1;
                        cmd.sum_add  = 1'b1;
                        state_next   = sts.len_zero ? ST_END : ST_DATA;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    cmd.data_write = 1'b1;
                    cmd.sum_add    = 1'b1;
                    if (sts.fill_last)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    state_next = sts.sum_ok ? ST_END : ST_HUNT;
                end
            end
            ST_END:
            begin
                rx_ready = sts.out_free;
                if (rx_valid && sts.out_free)
                begin
                    state_next = ST_HUNT;
                    if (sts.is_end)
                    begin
                        if (sts.held_zero)
                        begin
                            cmd.out_empty = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? ST_HUNT : ST_EMIT_RD;
                end
            end
            default:
            begin
                rx_ready = 1'b1;
                if (rx_valid)
                begin
                    if (sts.is_start)
                    begin
                        cmd.sum_load = 1'b1;
                        state_next   = ST_DIR;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SFR_ASSERT_NEXT(a_last_emit_hunts, clk, rst_n, cmd.emit_load && sts.emit_last, state_reg == ST_HUNT)
    `SFR_ASSERT_IMPL(a_no_input_in_run, clk, rst_n, state_reg == ST_EMIT_RD || state_reg == ST_EMIT_LD, !rx_ready)
    `SFR_ASSERT_NEXT(a_write_stays_in_frame, clk, rst_n, cmd.data_write, state_reg == ST_DATA || state_reg == ST_SUM)

endmodule
`default_nettype wire

// ===== hw/rtl/sfr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial frame receiver datapath
// Configuration registers, byte compares, running checksum, payload memory
// and the result output register.
// ============================================================================
`include "serial_frame_receiver_assert.svh"

module sfr_datapath import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    input  wire logic                 res_ready,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic                      res_valid,
    output result_t                   res_data
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] direction_code_reg;
    logic [BYTE_W-1:0] func_code_a_reg;
    logic [BYTE_W-1:0] func_code_b_reg;
    logic [BYTE_W-1:0] func_code_c_reg;
    logic [BYTE_W-1:0] end_byte_reg;

    logic [BYTE_W-1:0] held_function_reg;
    logic [CNT_W-1:0]  held_length_reg;
    logic [CNT_W-1:0]  fill_index_reg;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    result_t           res_data_reg;
    logic [CNT_W:0]    fill_inc;
    logic [CNT_W:0]    emit_inc;

    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

    assign fill_inc = {1'b0, fill_index_reg} + (CNT_W + 1)'(1);
    assign emit_inc = {1'b0, emit_idx_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        sts.is_start  = rx_byte == start_byte_reg;
        sts.is_dir    = rx_byte == direction_code_reg;
        sts.is_func   = (rx_byte == func_code_a_reg) || (rx_byte == func_code_b_reg)
                        || (rx_byte == func_code_c_reg);
        sts.len_ok    = rx_byte <= BYTE_W'(MAX_PAYLOAD);
        sts.len_zero  = rx_byte == '0;
        sts.fill_last = fill_inc >= {1'b0, held_length_reg};
        sts.sum_ok    = rx_byte == sum_reg;
        sts.is_end    = rx_byte == end_byte_reg;
        sts.held_zero = held_length_reg == '0;
        sts.out_free  = !res_valid_reg || res_ready;
        sts.emit_last = emit_inc == {1'b0, held_length_reg};
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.sum_load)
        begin
            sum_next = rx_byte;
        end
        else if (cmd.sum_add)
        begin
            sum_next = sum_reg + rx_byte;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.emit_load || cmd.out_empty)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg     <= RST_START_BYTE;
            direction_code_reg <= RST_DIRECTION_CODE;
            func_code_a_reg    <= RST_FUNC_CODE_A;
            func_code_b_reg    <= RST_FUNC_CODE_B;
            func_code_c_reg    <= RST_FUNC_CODE_C;
            end_byte_reg       <= RST_END_BYTE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_BYTE:     start_byte_reg     <= cfg_data;
                CFG_DIRECTION_CODE: direction_code_reg <= cfg_data;
                CFG_FUNC_CODE_A:    func_code_a_reg    <= cfg_data;
                CFG_FUNC_CODE_B:    func_code_b_reg    <= cfg_data;
                CFG_FUNC_CODE_C:    func_code_c_reg    <= cfg_data;
                CFG_END_BYTE:       end_byte_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_function_reg <= '0;
            held_length_reg   <= '0;
            fill_index_reg    <= '0;
            emit_idx_reg      <= '0;
            sum_reg           <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
            if (cmd.func_load)
            begin
                held_function_reg <= rx_byte;
            end
            if (cmd.len_load)
            begin
                held_length_reg <= rx_byte[CNT_W-1:0];
                fill_index_reg  <= '0;
                emit_idx_reg    <= '0;
            end
            if (cmd.data_write)
            begin
                fill_index_reg <= fill_inc[CNT_W-1:0];
            end
            if (cmd.emit_load)
            begin
                emit_idx_reg <= emit_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_write)
        begin
            mem[fill_index_reg[AW-1:0]] <= rx_byte;
        end
        rdata_reg <= mem[emit_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            res_data_reg.payload_byte   <= rdata_reg;
            res_data_reg.byte_position  <= POS_W'(emit_idx_reg);
            res_data_reg.frame_function <= held_function_reg;
            res_data_reg.frame_length   <= LEN_W'(held_length_reg);
            res_data_reg.last_of_frame  <= sts.emit_last;
            res_data_reg.empty_frame    <= 1'b0;
        end
        else if (cmd.out_empty)
        begin
            res_data_reg.payload_byte   <= '0;
            res_data_reg.byte_position  <= '0;
            res_data_reg.frame_function <= held_function_reg;
            res_data_reg.frame_length   <= LEN_W'(held_length_reg);
            res_data_reg.last_of_frame  <= 1'b1;
            res_data_reg.empty_frame    <= 1'b1;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `SFR_ASSERT_ALWAYS(a_fill_within_length, clk, rst_n, fill_index_reg <= held_length_reg)
    `SFR_ASSERT_IMPL(a_emit_within_length, clk, rst_n, cmd.emit_load, emit_idx_reg < held_length_reg)
    `SFR_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, cmd.emit_load || cmd.out_empty, !res_valid_reg || res_ready)

endmodule
`default_nettype wire

// ===== hw/rtl/serial_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Serial frame receiver
// Hunts for checksummed frames in a received byte stream and delivers the
// payload of each valid frame as a run of results.
// ============================================================================
// A received byte is taken as soon as it is offered, but for two cases. The
// end byte of a frame is held off only while the previous result still waits
// in the output register. A validated frame of N payload bytes then plays out
// as a run of N results, each a registered read of the payload memory
// followed by the load of the output register once it is free; no byte is
// taken during the run, and the byte after the run is taken while the last
// result still waits. An empty frame gives its single result straight from
// the end byte. The payload memory needs no clearing after reset.

module serial_frame_receiver import sfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    sfr_rx_if.sink    rx,
    sfr_res_if.source res,
    sfr_cfg_if.sink   cfg
);

    cmd_t    cmd;
    sts_t    sts;
    result_t res_data;

    assign cfg.ready = 1'b1;

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx.rx_byte),
        .cfg_write (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .res_ready (res.ready),
        .cmd       (cmd),
        .sts       (sts),
        .res_valid (res.valid),
        .res_data  (res_data)
    );

    assign res.payload_byte   = res_data.payload_byte;
    assign res.byte_position  = res_data.byte_position;
    assign res.frame_function = res_data.frame_function;
    assign res.frame_length   = res_data.frame_length;
    assign res.last_of_frame  = res_data.last_of_frame;
    assign res.empty_frame    = res_data.empty_frame;

endmodule
`default_nettype wire

// ===== tb/tb_serial_frame_receiver.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Serial frame receiver testbench
// Feeds byte streams with good, broken and oversize frames and noise through
// the receiver under random sender gaps and receiver stalls. Every result
// beat is checked against a parser model kept in step with the accepted
// bytes and register writes.
// ============================================================================
module tb_serial_frame_receiver;
    import sfr_pkg::*;

    localparam int MAX_PAYLOAD    = 32;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 45;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_0 = CFG_END_BYTE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_1 = CFG_END_BYTE + 3'd2;

    typedef enum logic [2:0] {
        HUNT, GET_DIR, GET_FUNC, GET_LEN, GET_DATA, GET_SUM, GET_END
    } rx_phase_e;

    typedef enum int {
        FRAME_GOOD, FRAME_NOISE, FRAME_BAD_DIR, FRAME_BAD_FUNC,
        FRAME_OVERSIZE, FRAME_BAD_SUM, FRAME_BAD_END
    } frame_kind_e;

    typedef struct {
        frame_kind_e kind;
        int          func_sel;
        int          len;
        logic [7:0]  fill;
        int          typed_count;
        result_t     typed;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    sfr_rx_if  rx_ch();
    sfr_res_if res_ch();
    sfr_cfg_if cfg_ch();

    serial_frame_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    // Parser model state.
    logic [7:0] cfg_regs [6];
    rx_phase_e  rx_phase;
    logic [7:0] held_fn;
    logic [5:0] held_len;
    logic [5:0] fill_idx;
    logic [7:0] frame_sum;
    logic [7:0] frame_payload [MAX_PAYLOAD];
    result_t    frame_results_due [$];

    logic [7:0] tx_bytes [$];
    logic [7:0] reg_settings [4][6];
    result_t    last_result;
    logic [15:0] stall_pattern;
    logic [3:0]  stall_slot = 4'd0;

    int mismatch_count = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    directed_row_t directed_rows [8] = '{
        '{FRAME_GOOD, 0, 0, 8'h00, 1,
          '{8'h00, 5'd0, RST_FUNC_CODE_A, 6'd0, 1'b1, 1'b1}},
        '{FRAME_GOOD, 1, 1, 8'hFF, 1,
          '{8'hFF, 5'd0, RST_FUNC_CODE_B, 6'd1, 1'b1, 1'b0}},
        '{FRAME_OVERSIZE, 2, MAX_PAYLOAD + 1, 8'h00, 0, '0},
        '{FRAME_BAD_DIR, 0, 0, RST_START_BYTE, 0, '0},
        '{FRAME_BAD_SUM, 1, 1, 8'h00, 0, '0},
        '{FRAME_BAD_END, 2, 0, 8'h00, 0, '0},
        '{FRAME_BAD_FUNC, 0, 0, 8'h00, 0, '0},
        '{FRAME_NOISE, 0, 2, 8'h00, 0, '0}
    };

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_result(input string tag, input result_t got, input result_t want);
        if (got.payload_byte !== want.payload_byte)
            report_mismatch({tag, " payload_byte"}, got.payload_byte, want.payload_byte);
        if (got.byte_position !== want.byte_position)
            report_mismatch({tag, " byte_position"}, got.byte_position, want.byte_position);
        if (got.frame_function !== want.frame_function)
            report_mismatch({tag, " frame_function"}, got.frame_function, want.frame_function);
        if (got.frame_length !== want.frame_length)
            report_mismatch({tag, " frame_length"}, got.frame_length, want.frame_length);
        if (got.last_of_frame !== want.last_of_frame)
            report_mismatch({tag, " last_of_frame"}, got.last_of_frame, want.last_of_frame);
        if (got.empty_frame !== want.empty_frame)
            report_mismatch({tag, " empty_frame"}, got.empty_frame, want.empty_frame);
    endtask

    function automatic void parse_rx_byte(input logic [7:0] b);
        result_t r;
        case (rx_phase)
            GET_DIR:
            begin
                if (b == cfg_regs[CFG_DIRECTION_CODE])
                begin
                    frame_sum = frame_sum + b;
                    rx_phase = GET_FUNC;
                end
                else
                    rx_phase = HUNT;
            end
            GET_FUNC:
            begin
                if (b == cfg_regs[CFG_FUNC_CODE_A] || b == cfg_regs[CFG_FUNC_CODE_B] ||
                    b == cfg_regs[CFG_FUNC_CODE_C])
                begin
                    held_fn = b;
                    frame_sum = frame_sum + b;
                    rx_phase = GET_LEN;
                end
                else
                    rx_phase = HUNT;
            end
            GET_LEN:
            begin
                if (b > MAX_PAYLOAD)
                    rx_phase = HUNT;
                else
                begin
                    held_len = b[5:0];
                    frame_sum = frame_sum + b;
                    fill_idx = 6'd0;
                    rx_phase = (b == 8'd0) ? GET_END : GET_DATA;
                end
            end
            GET_DATA:
            begin
                frame_payload[fill_idx[4:0]] = b;
                frame_sum = frame_sum + b;
                fill_idx = fill_idx + 6'd1;
                if (fill_idx >= held_len)
                    rx_phase = GET_SUM;
            end
            GET_SUM: rx_phase = (b == frame_sum) ? GET_END : HUNT;
            GET_END:
            begin
                if (b == cfg_regs[CFG_END_BYTE])
                begin
                    if (held_len == 6'd0)
                    begin
                        r = '{8'h00, 5'd0, held_fn, 6'd0, 1'b1, 1'b1};
                        frame_results_due.push_back(r);
                    end
                    else
                    begin
                        for (int i = 0; i < held_len; i++)
                        begin
                            r = '{frame_payload[i], 5'(i), held_fn, held_len,
                                  (i + 1 == held_len), 1'b0};
                            frame_results_due.push_back(r);
                        end
                    end
                end
                rx_phase = HUNT;
            end
            default:
            begin
                if (b == cfg_regs[CFG_START_BYTE])
                begin
                    frame_sum = b;
                    rx_phase = GET_DIR;
                end
                else
                    rx_phase = HUNT;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index <= CFG_END_BYTE)
                cfg_regs[cfg_ch.index] = cfg_ch.data;
            if (rx_ch.valid && rx_ch.ready)
                parse_rx_byte(rx_ch.rx_byte);
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.payload_byte, res_ch.byte_position, res_ch.frame_function,
                        res_ch.frame_length, res_ch.last_of_frame, res_ch.empty_frame};
                results_seen++;
                last_result = got;
                if (frame_results_due.size() == 0)
                    report_mismatch("result beat with nothing pending, position",
                                    got.byte_position, -1);
                else
                    compare_result("result", got, frame_results_due.pop_front());
            end
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("serial_frame_receiver regression: fail");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_slot == 4'd0)
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
        res_ch.ready = stall_pattern[stall_slot];
        stall_slot = stall_slot + 4'd1;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk) rx_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        rx_ch.valid = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge clk); while (!rx_ch.ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i]);
        frames_sent++;
    endtask

    task automatic wait_drain();
        @(negedge clk) rx_ch.valid = 1'b0;
        while (frame_results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk) cfg_ch.valid = 1'b0;
        reg_writes++;
    endtask

    task automatic build_frame(input frame_kind_e kind, input int sel, input int len,
                               input logic [7:0] fill, input bit rand_fill,
                               input bit headless, input logic [7:0] pre_sum);
        logic [7:0] fn;
        logic [7:0] sum;
        logic [7:0] wrong;
        logic [7:0] pb;
        tx_bytes.delete();
        if (kind == FRAME_NOISE)
        begin
            for (int i = 0; i < len; i++)
            begin
                if (rand_fill)
                    pb = ($urandom_range(0, 3) == 0) ? cfg_regs[CFG_START_BYTE]
                                                     : 8'($urandom);
                else
                    pb = i[0] ? ~fill : fill;
                tx_bytes.push_back(pb);
            end
            return;
        end
        fn = cfg_regs[CFG_FUNC_CODE_A + sel];
        sum = headless ? pre_sum : cfg_regs[CFG_START_BYTE] + cfg_regs[CFG_DIRECTION_CODE];
        if (!headless)
        begin
            tx_bytes.push_back(cfg_regs[CFG_START_BYTE]);
            if (kind == FRAME_BAD_DIR)
            begin
                tx_bytes.push_back((fill == cfg_regs[CFG_DIRECTION_CODE]) ? fill ^ 8'h01
                                                                          : fill);
                return;
            end
            tx_bytes.push_back(cfg_regs[CFG_DIRECTION_CODE]);
        end
        if (kind == FRAME_BAD_FUNC)
        begin
            wrong = fill;
            while (wrong == cfg_regs[CFG_FUNC_CODE_A] || wrong == cfg_regs[CFG_FUNC_CODE_B] ||
                   wrong == cfg_regs[CFG_FUNC_CODE_C])
                wrong = wrong + 8'd1;
            tx_bytes.push_back(wrong);
            return;
        end
        tx_bytes.push_back(fn);
        sum = sum + fn;
        tx_bytes.push_back(len[7:0]);
        if (kind == FRAME_OVERSIZE)
            return;
        sum = sum + len[7:0];
        for (int i = 0; i < len; i++)
        begin
            pb = rand_fill ? 8'($urandom) : fill;
            tx_bytes.push_back(pb);
            sum = sum + pb;
        end
        if (len != 0)
            tx_bytes.push_back((kind == FRAME_BAD_SUM) ? sum ^ (fill | 8'h01) : sum);
        tx_bytes.push_back((kind == FRAME_BAD_END) ? cfg_regs[CFG_END_BYTE] ^ (fill | 8'h01)
                                                   : cfg_regs[CFG_END_BYTE]);
    endtask

    initial
    begin
        directed_row_t row;
        frame_kind_e kind;
        int seen_before;
        int roll;
        int len;
        int good_frames;
        logic [7:0] pre_sum;

        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_START_BYTE;
        cfg_ch.data = 8'h00;
        cfg_regs = '{RST_START_BYTE, RST_DIRECTION_CODE, RST_FUNC_CODE_A,
                     RST_FUNC_CODE_B, RST_FUNC_CODE_C, RST_END_BYTE};
        rx_phase = HUNT;
        held_fn = 8'h00;
        held_len = 6'd0;
        fill_idx = 6'd0;
        frame_sum = 8'h00;
        good_frames = 0;
        reg_settings[0] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'hFF};
        reg_settings[1] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00};
        for (int r = 0; r < 6; r++)
            reg_settings[2][r] = 8'($urandom);
        reg_settings[3] = '{RST_START_BYTE, RST_DIRECTION_CODE, RST_FUNC_CODE_A,
                            RST_FUNC_CODE_B, RST_FUNC_CODE_C, RST_END_BYTE};

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            build_frame(row.kind, row.func_sel, row.len, row.fill, 1'b0, 1'b0, 8'h00);
            seen_before = results_seen;
            send_frame();
            wait_drain();
            if (results_seen - seen_before != row.typed_count)
                report_mismatch("directed frame result count", results_seen - seen_before,
                                row.typed_count);
            else if (row.typed_count > 0)
                compare_result("directed", last_result, row.typed);
        end

        for (int p = 0; p < 4; p++)
        begin
            wait_drain();
            // Odd settings are switched with a frame half received.
            pre_sum = cfg_regs[CFG_START_BYTE] + cfg_regs[CFG_DIRECTION_CODE];
            if (p % 2 == 1)
            begin
                send_byte(cfg_regs[CFG_START_BYTE]);
                send_byte(cfg_regs[CFG_DIRECTION_CODE]);
                wait_drain();
            end
            for (int r = CFG_START_BYTE; r <= CFG_END_BYTE; r++)
                write_reg(CFG_IDX_W'(r), reg_settings[p][r]);
            if (p == 0)
            begin
                write_reg(CFG_SPARE_0, 8'($urandom));
                write_reg(CFG_SPARE_1, 8'($urandom));
            end
            if (p % 2 == 1)
            begin
                build_frame(FRAME_GOOD, $urandom_range(0, 2), $urandom_range(0, 6),
                            8'($urandom), 1'b1, 1'b1, pre_sum);
                send_frame();
            end
            while (bytes_sent < 35 + (p + 1) * RANDOM_BYTES)
            begin
                roll = $urandom_range(0, 99);
                len = $urandom_range(0, 6);
                if (roll < 70)
                begin
                    kind = FRAME_GOOD;
                    good_frames++;
                    if (good_frames % 8 == 0)
                        len = MAX_PAYLOAD;
                    else if ($urandom_range(0, 7) == 0)
                        len = $urandom_range(7, MAX_PAYLOAD - 1);
                end
                else if (roll < 75)
                begin
                    kind = FRAME_NOISE;
                    len = $urandom_range(1, 4);
                end
                else if (roll < 80)
                    kind = FRAME_BAD_DIR;
                else if (roll < 85)
                    kind = FRAME_BAD_FUNC;
                else if (roll < 88)
                begin
                    kind = FRAME_OVERSIZE;
                    len = $urandom_range(MAX_PAYLOAD + 1, 255);
                end
                else if (roll < 94)
                begin
                    kind = FRAME_BAD_SUM;
                    len = $urandom_range(1, 6);
                end
                else
                    kind = FRAME_BAD_END;
                build_frame(kind, $urandom_range(0, 2), len, 8'($urandom), 1'b1, 1'b0, 8'h00);
                send_frame();
            end
        end

        wait_drain();
        repeat (2 * MAX_PAYLOAD + 16) @(posedge clk);
        if (frame_results_due.size() != 0)
            report_mismatch("results never delivered", frame_results_due.size(), 0);

        $display("Covered %0d input beats in %0d frames and %0d result beats.",
                 bytes_sent, frames_sent, results_seen);
        $display("Made %0d register writes over 4 settings; %0d mismatches.",
                 reg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("serial_frame_receiver regression: pass");
        else
            $display("serial_frame_receiver regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_rx_if.sv
hw/rtl/sfr_res_if.sv
hw/rtl/sfr_cfg_if.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/sfr_datapath.sv
hw/rtl/serial_frame_receiver.sv
tb/tb_serial_frame_receiver.sv
